// ----- rtl/core/bmp24_stream_to_rgb565_macros.svh -----
// assertion macros shared by the bmp24 rtl files
// uses the clock and reset names of the module that includes it
`ifndef BMP24_STREAM_TO_RGB565_MACROS_SVH
`define BMP24_STREAM_TO_RGB565_MACROS_SVH

// consequence must hold in the same cycle as the antecedent
`define BMP24_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bmp24_pkg.sv -----
// types, codes and constants of the bmp24 to rgb565 stream decoder
// used by every module in rtl/core; no dependencies
package bmp24_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_SKIP   = 3'd2,
      PH_PIXELS = 3'd3,
      PH_PAD    = 3'd4
   } phase_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_PIXEL     = 3'd0,
      ST_OFFSCREEN = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_PLANES    = 3'd3,
      ST_DEPTH     = 3'd4,
      ST_COMPRESS  = 3'd5,
      ST_OFFSET    = 3'd6
   } status_type;

   // register map
   localparam int ADDR_WIDTH = 4;
   localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
   localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

   localparam logic [15:0] ORIGIN_X_RESET      = 16'd0;
   localparam logic [15:0] ORIGIN_Y_RESET      = 16'd0;
   localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd160;
   localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd128;

   // byte positions that complete a header field
   localparam logic [31:0] POS_MAGIC    = 32'd1;
   localparam logic [31:0] POS_OFFSET   = 32'd13;
   localparam logic [31:0] POS_WIDTH    = 32'd21;
   localparam logic [31:0] POS_HEIGHT   = 32'd25;
   localparam logic [31:0] POS_PLANES   = 32'd27;
   localparam logic [31:0] POS_DEPTH    = 32'd29;
   localparam logic [31:0] POS_COMPRESS = 32'd33;
   localparam logic [31:0] HEADER_BYTES = 32'd34;

   // expected header values
   localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
   localparam logic [15:0] BMP_PLANES = 16'd1;
   localparam logic [15:0] BMP_DEPTH  = 16'd24;

   // colour truncation masks
   localparam logic [7:0] RED_BLUE_MASK = 8'hF8;
   localparam logic [7:0] GREEN_MASK    = 8'hFC;

   // configuration seen by the parser
   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] screen_width;
      logic [15:0] screen_height;
   } cfg_type;

   // one result from the parser
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] color;
      logic        last;
   } result_type;

endpackage

// ----- rtl/core/bmp24_csr.sv -----
// configuration registers of the bmp24 decoder behind an apb-style port
// depends on bmp24_pkg
module bmp24_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bmp24_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output bmp24_pkg::cfg_type                  cfg
);

   logic        wr_en;
   logic [1:0]  reg_idx;
   logic [15:0] origin_x_ff, origin_y_ff, screen_width_ff, screen_height_ff;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[3:2];

   // register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= bmp24_pkg::ORIGIN_X_RESET;
         origin_y_ff      <= bmp24_pkg::ORIGIN_Y_RESET;
         screen_width_ff  <= bmp24_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= bmp24_pkg::SCREEN_HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            bmp24_pkg::REG_ORIGIN_X:      origin_x_ff      <= pwdata[15:0];
            bmp24_pkg::REG_ORIGIN_Y:      origin_y_ff      <= pwdata[15:0];
            bmp24_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= pwdata[15:0];
            bmp24_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         bmp24_pkg::REG_ORIGIN_X:      prdata = {16'd0, origin_x_ff};
         bmp24_pkg::REG_ORIGIN_Y:      prdata = {16'd0, origin_y_ff};
         bmp24_pkg::REG_SCREEN_WIDTH:  prdata = {16'd0, screen_width_ff};
         bmp24_pkg::REG_SCREEN_HEIGHT: prdata = {16'd0, screen_height_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   assign cfg.origin_x      = origin_x_ff;
   assign cfg.origin_y      = origin_y_ff;
   assign cfg.screen_width  = screen_width_ff;
   assign cfg.screen_height = screen_height_ff;

endmodule

// ----- rtl/core/bmp24_parse.sv -----
// header parser, pixel assembler and coordinate counters of the bmp24 decoder
// depends on bmp24_pkg and bmp24_stream_to_rgb565_macros.svh
`include "bmp24_stream_to_rgb565_macros.svh"

module bmp24_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [7:0]             data_byte,
   input  logic                   start_of_file,
   input  bmp24_pkg::cfg_type     cfg,
   output bmp24_pkg::result_type  res
);

   bmp24_pkg::phase_type phase_ff, phase_in;
   logic [31:0] file_pos_ff, file_pos_in;
   logic [31:0] field_shift_ff, field_shift_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [15:0] img_width_ff, img_width_in;
   logic [15:0] img_height_ff, img_height_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] rows_left_ff, rows_left_in;
   logic [15:0] cur_row_ff, cur_row_in;
   logic [1:0]  bip_ff, bip_in;
   logic [15:0] blue_green_ff, blue_green_in;
   logic [1:0]  pad_left_ff, pad_left_in;

   // state as seen by this byte, after a start restart
   bmp24_pkg::phase_type phase_cur;
   logic [31:0] pos_cur, shift_cur, dstart_cur;
   logic [15:0] width_cur, height_cur;
   logic [31:0] shift_new, pos_inc;
   logic [15:0] column_inc, rows_dec;
   logic [1:0]  pad_dec;
   logic [7:0]  red_m, green_m, blue_m;
   logic        offscreen;

   // origin is signed, screen size unsigned
   assign offscreen = (!cfg.origin_x[15] && (cfg.origin_x >= cfg.screen_width)) ||
                      (!cfg.origin_y[15] && (cfg.origin_y >= cfg.screen_height));

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= bmp24_pkg::PH_IDLE;
         file_pos_ff    <= 32'd0;
         field_shift_ff <= 32'd0;
         data_start_ff  <= 32'd0;
         img_width_ff   <= 16'd0;
         img_height_ff  <= 16'd0;
         column_ff      <= 16'd0;
         rows_left_ff   <= 16'd0;
         cur_row_ff     <= 16'd0;
         bip_ff         <= 2'd0;
         blue_green_ff  <= 16'd0;
         pad_left_ff    <= 2'd0;
      end else begin
         phase_ff       <= phase_in;
         file_pos_ff    <= file_pos_in;
         field_shift_ff <= field_shift_in;
         data_start_ff  <= data_start_in;
         img_width_ff   <= img_width_in;
         img_height_ff  <= img_height_in;
         column_ff      <= column_in;
         rows_left_ff   <= rows_left_in;
         cur_row_ff     <= cur_row_in;
         bip_ff         <= bip_in;
         blue_green_ff  <= blue_green_in;
         pad_left_ff    <= pad_left_in;
      end
   end

   // next state and result for one byte
   always_comb begin
      phase_in       = phase_ff;
      file_pos_in    = file_pos_ff;
      field_shift_in = field_shift_ff;
      data_start_in  = data_start_ff;
      img_width_in   = img_width_ff;
      img_height_in  = img_height_ff;
      column_in      = column_ff;
      rows_left_in   = rows_left_ff;
      cur_row_in     = cur_row_ff;
      bip_in         = bip_ff;
      blue_green_in  = blue_green_ff;
      pad_left_in    = pad_left_ff;
      res            = '0;

      phase_cur  = start_of_file ? bmp24_pkg::PH_HEADER : phase_ff;
      pos_cur    = start_of_file ? 32'd0 : file_pos_ff;
      shift_cur  = start_of_file ? 32'd0 : field_shift_ff;
      dstart_cur = start_of_file ? 32'd0 : data_start_ff;
      width_cur  = start_of_file ? 16'd0 : img_width_ff;
      height_cur = start_of_file ? 16'd0 : img_height_ff;
      shift_new  = {data_byte, shift_cur[31:8]};
      pos_inc    = pos_cur + 32'd1;
      column_inc = column_ff + 16'd1;
      rows_dec   = rows_left_ff - 16'd1;
      pad_dec    = pad_left_ff - 2'd1;
      red_m      = data_byte & bmp24_pkg::RED_BLUE_MASK;
      green_m    = blue_green_ff[15:8] & bmp24_pkg::GREEN_MASK;
      blue_m     = blue_green_ff[7:0] & bmp24_pkg::RED_BLUE_MASK;

      if (advance) begin
         // restart clears the file state
         if (start_of_file) begin
            phase_in      = bmp24_pkg::PH_HEADER;
            file_pos_in   = 32'd0;
            field_shift_in = 32'd0;
            data_start_in = 32'd0;
            img_width_in  = 16'd0;
            img_height_in = 16'd0;
            column_in     = 16'd0;
            rows_left_in  = 16'd0;
            bip_in        = 2'd0;
            blue_green_in = 16'd0;
            pad_left_in   = 2'd0;
         end

         if (start_of_file && offscreen) begin
            phase_in   = bmp24_pkg::PH_IDLE;
            res.valid  = 1'b1;
            res.status = bmp24_pkg::ST_OFFSCREEN;
            res.last   = 1'b1;
         end else begin
            unique case (phase_cur)
               bmp24_pkg::PH_HEADER: begin
                  field_shift_in = shift_new;
                  file_pos_in    = pos_inc;
                  unique case (pos_cur)
                     bmp24_pkg::POS_MAGIC: begin
                        if (shift_new[31:16] != bmp24_pkg::BMP_MAGIC) begin
                           phase_in   = bmp24_pkg::PH_IDLE;
                           res.valid  = 1'b1;
                           res.status = bmp24_pkg::ST_MAGIC;
                           res.last   = 1'b1;
                        end
                     end
                     bmp24_pkg::POS_OFFSET: data_start_in = shift_new;
                     bmp24_pkg::POS_WIDTH:  img_width_in  = shift_new[15:0];
                     bmp24_pkg::POS_HEIGHT: img_height_in = shift_new[15:0];
                     bmp24_pkg::POS_PLANES: begin
                        if (shift_new[31:16] != bmp24_pkg::BMP_PLANES) begin
                           phase_in   = bmp24_pkg::PH_IDLE;
                           res.valid  = 1'b1;
                           res.status = bmp24_pkg::ST_PLANES;
                           res.last   = 1'b1;
                        end
                     end
                     bmp24_pkg::POS_DEPTH: begin
                        if (shift_new[31:16] != bmp24_pkg::BMP_DEPTH) begin
                           phase_in   = bmp24_pkg::PH_IDLE;
                           res.valid  = 1'b1;
                           res.status = bmp24_pkg::ST_DEPTH;
                           res.last   = 1'b1;
                        end
                     end
                     bmp24_pkg::POS_COMPRESS: begin
                        // compression first, then the data offset
                        priority if (shift_new != 32'd0) begin
                           phase_in   = bmp24_pkg::PH_IDLE;
                           res.valid  = 1'b1;
                           res.status = bmp24_pkg::ST_COMPRESS;
                           res.last   = 1'b1;
                        end else if (dstart_cur < bmp24_pkg::HEADER_BYTES) begin
                           phase_in   = bmp24_pkg::PH_IDLE;
                           res.valid  = 1'b1;
                           res.status = bmp24_pkg::ST_OFFSET;
                           res.last   = 1'b1;
                        end else begin
                           column_in     = 16'd0;
                           bip_in        = 2'd0;
                           blue_green_in = 16'd0;
                           pad_left_in   = 2'd0;
                           rows_left_in  = height_cur;
                           cur_row_in    = cfg.origin_y + height_cur - 16'd1;
                           priority if (width_cur == 16'd0 || height_cur == 16'd0)
                              phase_in = bmp24_pkg::PH_IDLE;
                           else if (dstart_cur == bmp24_pkg::HEADER_BYTES)
                              phase_in = bmp24_pkg::PH_PIXELS;
                           else
                              phase_in = bmp24_pkg::PH_SKIP;
                        end
                     end
                     default: ;
                  endcase
               end

               bmp24_pkg::PH_SKIP: begin
                  file_pos_in = pos_inc;
                  if (pos_inc == data_start_ff)
                     phase_in = bmp24_pkg::PH_PIXELS;
               end

               bmp24_pkg::PH_PIXELS: begin
                  unique case (bip_ff)
                     2'd1: begin
                        blue_green_in = {data_byte, blue_green_ff[7:0]} | blue_green_ff;
                        bip_in        = 2'd2;
                     end
                     2'd2: begin
                        // red byte completes the pixel
                        bip_in      = 2'd0;
                        res.valid   = 1'b1;
                        res.status  = bmp24_pkg::ST_PIXEL;
                        res.color   = {red_m[7:3], green_m[7:2], blue_m[7:3]};
                        res.pixel_x = cfg.origin_x + column_ff;
                        res.pixel_y = cur_row_ff;
                        column_in   = column_inc;
                        if (column_inc == img_width_ff) begin
                           column_in    = 16'd0;
                           rows_left_in = rows_dec;
                           cur_row_in   = cur_row_ff - 16'd1;
                           priority if (rows_dec == 16'd0) begin
                              res.last = 1'b1;
                              phase_in = bmp24_pkg::PH_IDLE;
                           end else if (img_width_ff[1:0] != 2'd0) begin
                              pad_left_in = img_width_ff[1:0];
                              phase_in    = bmp24_pkg::PH_PAD;
                           end
                        end
                     end
                     default: begin
                        // blue byte opens a pixel
                        blue_green_in = {8'd0, data_byte};
                        bip_in        = 2'd1;
                     end
                  endcase
               end

               bmp24_pkg::PH_PAD: begin
                  pad_left_in = pad_dec;
                  if (pad_dec == 2'd0)
                     phase_in = bmp24_pkg::PH_PIXELS;
               end

               default: ;
            endcase
         end
      end
   end

   // an error result always leaves the parser idle
   `BMP24_ASSERT_NEXT(a_err_goes_idle, advance && res.valid && (res.status != bmp24_pkg::ST_PIXEL), phase_ff == bmp24_pkg::PH_IDLE, "error result did not idle the parser")
   // rows remain whenever pixels are still expected
   `BMP24_ASSERT_SAME(a_rows_left, (phase_ff == bmp24_pkg::PH_PIXELS) || (phase_ff == bmp24_pkg::PH_PAD), rows_left_ff != 16'd0, "pixel phase with no rows left")

endmodule

// ----- rtl/core/bmp24_stream_to_rgb565.sv -----
// top level of the bmp24 to rgb565 stream decoder: input and result registers
// depends on bmp24_pkg, bmp24_csr, bmp24_parse and the assertion macro header
`include "bmp24_stream_to_rgb565_macros.svh"

// Takes a 24-bit BMP file one byte per transfer and gives one RGB565 pixel
// per blue, green, red triple, with screen coordinates (rows bottom-up),
// or one coded error result with last set. A byte with start_of_file high
// restarts the parser. The decoder takes one byte every cycle while the
// input is not stalled: each byte passes an input register, the
// combinational parsing logic and the result register, and the input
// stalls only while a byte is held behind a waiting result that is stalled
// at the output. Configuration registers are to be written through the
// APB-style port only while the stream is quiet; the block itself does
// not enforce this.
module bmp24_stream_to_rgb565 (
   input  logic                                clock,
   input  logic                                reset,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_start_of_file,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_status,
   output logic signed [15:0]                  rsp_pixel_x,
   output logic signed [15:0]                  rsp_pixel_y,
   output logic [15:0]                         rsp_color,
   output logic                                rsp_last,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bmp24_pkg::ADDR_WIDTH-1:0]    paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   bmp24_pkg::cfg_type    cfg;
   bmp24_pkg::result_type res;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_status_ff;
   logic [15:0] out_px_ff, out_py_ff, out_color_ff;
   logic        out_last_ff;
   logic        out_load;
   logic        advance;

   bmp24_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // result register free or being drained this cycle
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;

   bmp24_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .data_byte     (in_byte_ff),
      .start_of_file (in_start_ff),
      .cfg           (cfg),
      .res           (res)
   );

   // input register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_start_of_file;
      end
   end

   // result register
   assign out_valid_in = out_load ? res.valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && res.valid) begin
         out_status_ff <= res.status;
         out_px_ff     <= res.pixel_x;
         out_py_ff     <= res.pixel_y;
         out_color_ff  <= res.color;
         out_last_ff   <= res.last;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_pixel_x = out_px_ff;
   assign rsp_pixel_y = out_py_ff;
   assign rsp_color   = out_color_ff;
   assign rsp_last    = out_last_ff;

   // error results carry zero fields and close the file
   `BMP24_ASSERT_SAME(a_err_fields,
      rsp_valid && (rsp_status != bmp24_pkg::ST_PIXEL),
      rsp_last && (rsp_color == 16'd0) && (rsp_pixel_x == 16'sd0) && (rsp_pixel_y == 16'sd0),
      "error result with non-zero fields")
   // the input only stalls behind a held byte
   `BMP24_ASSERT_SAME(a_stall_held,
      req_stall,
      in_valid_ff && out_valid_ff && rsp_stall,
      "input stalled without a blocked result")

endmodule
